/* rtl/core/hrp_pkg.sv */
// ----------------------------------------------------------------------------
// hrp_pkg
// shared types, codes and the method name lookup of the request head parser
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned METHOD_KEEP  = 7;
    localparam int unsigned METHOD_W     = BYTE_W * METHOD_KEEP;
    localparam int unsigned METHOD_COUNT = 9;
    localparam int unsigned OUT_DATA_W   = 24;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;

    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_METHOD  = 3'd1;
    localparam logic [2:0] KIND_PATH    = 3'd2;
    localparam logic [2:0] KIND_VERSION = 3'd3;
    localparam logic [2:0] KIND_NAME    = 3'd4;
    localparam logic [2:0] KIND_VALUE   = 3'd5;

    localparam logic [2:0] CLOSED_NONE    = 3'd0;
    localparam logic [2:0] CLOSED_METHOD  = 3'd1;
    localparam logic [2:0] CLOSED_PATH    = 3'd2;
    localparam logic [2:0] CLOSED_VERSION = 3'd3;
    localparam logic [2:0] CLOSED_NAME    = 3'd4;

    localparam logic [1:0] OUTC_RUNNING    = 2'd0;
    localparam logic [1:0] OUTC_COMPLETE   = 2'd1;
    localparam logic [1:0] OUTC_ERROR      = 2'd2;
    localparam logic [1:0] OUTC_INCOMPLETE = 2'd3;

    localparam logic [3:0] CODE_NO_MATCH = 4'd0;

    // method names, first byte in the low byte, unused bytes zero
    localparam logic [METHOD_W-1:0] METHOD_NAMES [METHOD_COUNT] = '{
        56'h00000000544547,
        56'h00000054534F50,
        56'h00000000545550,
        56'h004554454C4544,
        56'h00000044414548,
        56'h534E4F4954504F,
        56'h5443454E4E4F43,
        56'h00004843544150,
        56'h00004543415254
    };
    localparam logic [3:0] METHOD_LENS [METHOD_COUNT] = '{
        4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7, 4'd7, 4'd5, 4'd5
    };

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
        logic              is_cr;
        logic              is_lf;
        logic              is_sp;
        logic              is_tab;
        logic              is_colon;
    } hrp_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] echo_byte;
        logic [2:0]        byte_kind;
        logic [2:0]        field_closed;
        logic              header_added;
        logic [3:0]        method_code;
        logic [1:0]        outcome;
        logic              request_end;
    } hrp_result_t;

    function automatic logic [3:0] method_lookup(
        input logic [METHOD_W-1:0] chars,
        input logic [3:0]          len
    );
        logic [3:0] code;
        code = CODE_NO_MATCH;
        for (int k = 0; k < METHOD_COUNT; k++)
        begin
            if (code == CODE_NO_MATCH && len == METHOD_LENS[k] &&
                chars == METHOD_NAMES[k])
            begin
                code = 4'(k + 1);
            end
        end
        return code;
    endfunction

endpackage

/* rtl/core/hrp_front.sv */
// ----------------------------------------------------------------------------
// hrp_front
// input stage: takes request words and tags delimiter characters
// ----------------------------------------------------------------------------
module hrp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [hrp_pkg::BYTE_W-1:0] s_axis_tdata,
    input  logic                       s_axis_tlast,
    output logic                       item_valid,
    input  logic                       item_ready,
    output hrp_pkg::hrp_item_t         item
);

    logic               valid_reg;
    logic               valid_next;
    hrp_pkg::hrp_item_t item_reg;
    hrp_pkg::hrp_item_t item_next;
    logic               take;

    assign s_axis_tready = !valid_reg || item_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        item_next.data_byte = s_axis_tdata;
        item_next.last_byte = s_axis_tlast;
        item_next.is_cr     = (s_axis_tdata == hrp_pkg::CH_CR);
        item_next.is_lf     = (s_axis_tdata == hrp_pkg::CH_LF);
        item_next.is_sp     = (s_axis_tdata == hrp_pkg::CH_SP);
        item_next.is_tab    = (s_axis_tdata == hrp_pkg::CH_TAB);
        item_next.is_colon  = (s_axis_tdata == hrp_pkg::CH_COLON);
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/core/hrp_queue.sv */
// ----------------------------------------------------------------------------
// hrp_queue
// two-entry queue between the input stage and the parser
// ----------------------------------------------------------------------------
module hrp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  hrp_pkg::hrp_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_ready,
    output hrp_pkg::hrp_item_t rd_item
);

    hrp_pkg::hrp_item_t mem [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               push;
    logic               pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

/* rtl/core/hrp_back.sv */
// ----------------------------------------------------------------------------
// hrp_back
// parser state machine and result register
// ----------------------------------------------------------------------------
module hrp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  hrp_pkg::hrp_item_t   item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output hrp_pkg::hrp_result_t res
);

    typedef enum logic [3:0] {
        PH_METHOD,
        PH_PATH,
        PH_VERSION,
        PH_VER_LF,
        PH_LINE,
        PH_LINE_CR,
        PH_NAME,
        PH_SKIP,
        PH_VALUE,
        PH_VAL_LF,
        PH_DONE_OK,
        PH_DONE_ERR
    } phase_t;

    phase_t                        phase_reg;
    phase_t                        phase_next;
    phase_t                        phase_step;
    logic [hrp_pkg::METHOD_W-1:0]  chars_reg;
    logic [hrp_pkg::METHOD_W-1:0]  chars_next;
    logic [3:0]                    len_reg;
    logic [3:0]                    len_next;
    logic [3:0]                    code_reg;
    logic [3:0]                    code_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    hrp_pkg::hrp_result_t          out_reg;
    hrp_pkg::hrp_result_t          out_next;
    logic                          pop;
    logic                          crlf;
    logic                          failed;
    logic [3:0]                    code_w;

    assign item_ready = !out_valid_reg || res_ready;
    assign pop        = item_valid && item_ready;
    assign crlf       = item.is_cr || item.is_lf;

    always_comb
    begin
        phase_step            = phase_reg;
        chars_next            = chars_reg;
        len_next              = len_reg;
        code_w                = code_reg;
        failed                = 1'b0;
        out_next.echo_byte    = item.data_byte;
        out_next.byte_kind    = hrp_pkg::KIND_NONE;
        out_next.field_closed = hrp_pkg::CLOSED_NONE;
        out_next.header_added = 1'b0;
        out_next.outcome      = hrp_pkg::OUTC_RUNNING;
        out_next.request_end  = item.last_byte;
        case (phase_reg)
            PH_METHOD:
            begin
                if (item.is_sp)
                begin
                    out_next.field_closed = hrp_pkg::CLOSED_METHOD;
                    phase_step            = PH_PATH;
                    code_w = hrp_pkg::method_lookup(chars_reg, len_reg);
                end
                else if (crlf)
                begin
                    failed = 1'b1;
                end
                else
                begin
                    out_next.byte_kind = hrp_pkg::KIND_METHOD;
                    if (len_reg < 4'd7)
                    begin
                        chars_next[hrp_pkg::BYTE_W*len_reg[2:0] +: hrp_pkg::BYTE_W] =
                            item.data_byte;
                    end
                    if (len_reg != 4'd15)
                    begin
                        len_next = len_reg + 4'd1;
                    end
                end
            end
            PH_PATH:
            begin
                if (item.is_sp)
                begin
                    out_next.field_closed = hrp_pkg::CLOSED_PATH;
                    phase_step            = PH_VERSION;
                end
                else if (crlf)
                begin
                    failed = 1'b1;
                end
                else
                begin
                    out_next.byte_kind = hrp_pkg::KIND_PATH;
                end
            end
            PH_VERSION:
            begin
                if (item.is_cr)
                begin
                    out_next.field_closed = hrp_pkg::CLOSED_VERSION;
                    phase_step            = PH_VER_LF;
                end
                else if (item.is_lf)
                begin
                    out_next.field_closed = hrp_pkg::CLOSED_VERSION;
                    phase_step            = PH_LINE;
                end
                else
                begin
                    out_next.byte_kind = hrp_pkg::KIND_VERSION;
                end
            end
            PH_VER_LF, PH_VAL_LF:
            begin
                if (item.is_lf)
                begin
                    phase_step = PH_LINE;
                end
                else
                begin
                    failed = 1'b1;
                end
            end
            PH_LINE:
            begin
                if (item.is_cr)
                begin
                    phase_step = PH_LINE_CR;
                end
                else if (item.is_lf)
                begin
                    phase_step = PH_DONE_OK;
                end
                else if (item.is_colon)
                begin
                    out_next.field_closed = hrp_pkg::CLOSED_NAME;
                    phase_step            = PH_SKIP;
                end
                else
                begin
                    out_next.byte_kind = hrp_pkg::KIND_NAME;
                    phase_step         = PH_NAME;
                end
            end
            PH_LINE_CR:
            begin
                if (item.is_lf)
                begin
                    phase_step = PH_DONE_OK;
                end
                else
                begin
                    failed = 1'b1;
                end
            end
            PH_NAME:
            begin
                if (item.is_colon)
                begin
                    out_next.field_closed = hrp_pkg::CLOSED_NAME;
                    phase_step            = PH_SKIP;
                end
                else if (crlf)
                begin
                    failed = 1'b1;
                end
                else
                begin
                    out_next.byte_kind = hrp_pkg::KIND_NAME;
                end
            end
            PH_SKIP, PH_VALUE:
            begin
                if (item.is_cr)
                begin
                    out_next.header_added = 1'b1;
                    phase_step            = PH_VAL_LF;
                end
                else if (item.is_lf)
                begin
                    out_next.header_added = 1'b1;
                    phase_step            = PH_LINE;
                end
                else if (phase_reg == PH_SKIP && (item.is_sp || item.is_tab))
                begin
                    phase_step = PH_SKIP;
                end
                else
                begin
                    out_next.byte_kind = hrp_pkg::KIND_VALUE;
                    phase_step         = PH_VALUE;
                end
            end
            default:
            begin
                phase_step = phase_reg;
            end
        endcase

        // a failed method leaves no bytes behind
        if (failed)
        begin
            phase_step = PH_DONE_ERR;
            if (phase_reg == PH_METHOD)
            begin
                chars_next = '0;
                len_next   = '0;
            end
        end

        if (phase_step == PH_DONE_OK)
        begin
            out_next.outcome = hrp_pkg::OUTC_COMPLETE;
        end
        else if (phase_step == PH_DONE_ERR)
        begin
            out_next.outcome = hrp_pkg::OUTC_ERROR;
        end
        else if (item.last_byte)
        begin
            if (phase_step == PH_LINE)
            begin
                out_next.outcome = hrp_pkg::OUTC_INCOMPLETE;
            end
            else
            begin
                if (phase_step == PH_SKIP || phase_step == PH_VALUE)
                begin
                    out_next.header_added = 1'b1;
                end
                out_next.outcome = hrp_pkg::OUTC_ERROR;
            end
        end

        out_next.method_code = (phase_step == PH_METHOD) ? hrp_pkg::CODE_NO_MATCH : code_w;

        // next request starts after the last word
        if (item.last_byte)
        begin
            phase_next = PH_METHOD;
            chars_next = '0;
            len_next   = '0;
            code_next  = hrp_pkg::CODE_NO_MATCH;
        end
        else
        begin
            phase_next = phase_step;
            code_next  = out_next.method_code;
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_METHOD;
            chars_reg     <= '0;
            len_reg       <= '0;
            code_reg      <= hrp_pkg::CODE_NO_MATCH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg <= phase_next;
                chars_reg <= chars_next;
                len_reg   <= len_next;
                code_reg  <= code_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_no_code_in_method: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_METHOD |-> code_reg == hrp_pkg::CODE_NO_MATCH)
        else $error("method code set while the method is open");

    a_complete_untagged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.outcome == hrp_pkg::OUTC_COMPLETE
        |-> out_reg.byte_kind == hrp_pkg::KIND_NONE)
        else $error("word tagged after request complete");

    a_closed_untagged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.field_closed != hrp_pkg::CLOSED_NONE
        |-> out_reg.byte_kind == hrp_pkg::KIND_NONE)
        else $error("closing delimiter tagged as field data");

    a_new_request_clean: assert property (@(posedge clk) disable iff (!rst_n)
        pop && item.last_byte |=> phase_reg == PH_METHOD && len_reg == 4'd0)
        else $error("state not cleared after last word");

endmodule

/* rtl/core/http_request_head_parser_core.sv */
// ----------------------------------------------------------------------------
// http_request_head_parser_core
// request head parser: tags each request word as method, path, version,
// header name or header value and reports the parse outcome
// ----------------------------------------------------------------------------
// One word per cycle sustained, with both streams free of stalls. A word is
// registered and tagged in the input stage, waits in a two-entry queue, and
// is parsed by the state machine into the result register. The throughput
// is set by the parser state machine, which handles one word per cycle.
module http_request_head_parser_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // data_byte
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // echo_byte, field_closed, header_added, method_code, outcome, zero fill
    output logic [hrp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [2:0]                     m_axis_tuser,  // byte_kind
    output logic                           m_axis_tlast
);

    logic                 front_valid;
    logic                 front_ready;
    hrp_pkg::hrp_item_t   front_item;
    logic                 queue_valid;
    logic                 queue_ready;
    hrp_pkg::hrp_item_t   queue_item;
    hrp_pkg::hrp_result_t result;

    hrp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .item_valid    (front_valid),
        .item_ready    (front_ready),
        .item          (front_item)
    );

    hrp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_item  (queue_item)
    );

    hrp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (result)
    );

    assign m_axis_tdata = {6'd0, result.outcome, result.method_code,
                           result.header_added, result.field_closed, result.echo_byte};
    assign m_axis_tuser = result.byte_kind;
    assign m_axis_tlast = result.request_end;

endmodule
